// ===== hw/rtl/slc_pkg.sv =====
// Shared types and constants for the size-budgeted LRU cache.
// No dependencies; used by slc_cell and size_budget_lru_cache.
`default_nettype none
package slc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int HASH_W       = 64;
    localparam int TAG_W        = 64;
    localparam int SIZE_W       = 32;
    localparam int STAMP_W      = 32;
    localparam int EVICT_W      = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_W        = 32;
    localparam int S_TDATA_W    = 160;
    localparam int M_TDATA_W    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET   = 1'd1;

    localparam logic [SIZE_W-1:0] BUDGET_RST  = 32'd16777216;
    localparam logic [EVICT_W-1:0] EVICT_MAX  = 5'd31;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOKUP = 6'b000010,
        ST_DROP   = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_SEARCH = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // per-cell command: load new entry, clear entry, refresh stamp
    typedef struct packed {
        logic wr;
        logic drop;
        logic touch;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/slc_cell.sv =====
// One cache entry plus one stage of the LRU search chain.
// Depends on slc_pkg.
`default_nettype none
module slc_cell #(
    parameter int IDX_W = 4
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire slc_pkg::cell_ctrl_t         ctrl,
    input  wire logic [slc_pkg::HASH_W-1:0]  req_hash,
    input  wire logic [slc_pkg::TAG_W-1:0]   req_tag,
    input  wire logic [slc_pkg::SIZE_W-1:0]  req_size,
    input  wire logic [slc_pkg::STAMP_W-1:0] now,
    input  wire logic [IDX_W-1:0]            my_idx,
    // search link from the lower neighbor
    input  wire logic                        lnk_ok,
    input  wire logic [slc_pkg::STAMP_W-1:0] lnk_age,
    input  wire logic [IDX_W-1:0]            lnk_idx,
    input  wire logic [slc_pkg::SIZE_W-1:0]  lnk_bytes,
    // search link to the upper neighbor
    output logic                             out_ok,
    output logic [slc_pkg::STAMP_W-1:0]      out_age,
    output logic [IDX_W-1:0]                 out_idx,
    output logic [slc_pkg::SIZE_W-1:0]       out_bytes,
    output logic                             valid,
    output logic                             hit,
    output logic                             stale,
    output logic [slc_pkg::SIZE_W-1:0]       bytes
);

    logic                        valid_reg;
    logic [slc_pkg::HASH_W-1:0]  hash_reg;
    logic [slc_pkg::TAG_W-1:0]   tag_reg;
    logic [slc_pkg::SIZE_W-1:0]  bytes_reg;
    logic [slc_pkg::STAMP_W-1:0] stamp_reg;

    logic                        ok_reg;
    logic [slc_pkg::STAMP_W-1:0] age_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [slc_pkg::SIZE_W-1:0]  lb_reg;

    logic [slc_pkg::STAMP_W-1:0] my_age;
    logic                        take;

    assign my_age = now - stamp_reg;
    // strict compare: lower index keeps ties
    assign take   = valid_reg && (!lnk_ok || (my_age > lnk_age));

    assign hit   = valid_reg && (hash_reg == req_hash) && (tag_reg == req_tag);
    assign stale = valid_reg && ((hash_reg == req_hash) || (stamp_reg == now));
    assign valid = valid_reg;
    assign bytes = bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.wr)
                valid_reg <= 1'b1;
            else if (ctrl.drop)
                valid_reg <= 1'b0;
            ok_reg <= take || lnk_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            hash_reg  <= req_hash;
            tag_reg   <= req_tag;
            bytes_reg <= req_size;
        end
        if (ctrl.wr || ctrl.touch)
            stamp_reg <= now;
        if (take)
        begin
            age_reg <= my_age;
            idx_reg <= my_idx;
            lb_reg  <= bytes_reg;
        end
        else
        begin
            age_reg <= lnk_age;
            idx_reg <= lnk_idx;
            lb_reg  <= lnk_bytes;
        end
    end

    assign out_ok    = ok_reg;
    assign out_age   = age_reg;
    assign out_idx   = idx_reg;
    assign out_bytes = lb_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/size_budget_lru_cache.sv =====
// Top level of the size-budgeted LRU cache: controller and a chain of entry cells.
// Depends on slc_pkg and slc_cell.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: key_hash, content_tag, entry_size
//  m_*     | out | m_tvalid/m_tready  | m_tdata: hit, inserted, evicted_count, total_size
//  cfg_*   | in  | cfg_we             | cfg_index 0 min_entry_size, 1 size_budget
//
// A hit or a rejected miss passes IDLE, LOOKUP and FINISH; the result is registered
// in FINISH once the result register is free. A miss that inserts drops one
// same-hash/same-stamp entry per DROP cycle, then goes to CHECK; each LRU eviction
// goes from CHECK to SEARCH, where the search token walks the cell chain, and back.
// Reset clears all valid bits, the total and the access clock at once.
// The result register decouples the sides: a new item is taken while the
// previous result waits; the controller only holds in FINISH if it is still full.
`default_nettype none
module size_budget_lru_cache #(
    parameter int ENTRIES = slc_pkg::ENTRIES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [63:0] key_hash, [127:64] content_tag, [159:128] entry_size
    input  wire logic [slc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] hit, [1] inserted, [6:2] evicted_count, [38:7] total_size, [39] zero
    output logic [slc_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [slc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slc_pkg::CFG_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    slc_pkg::state_t state_reg, state_next;

    logic [slc_pkg::SIZE_W-1:0]  min_reg, budget_reg;
    logic [slc_pkg::SIZE_W-1:0]  used_reg, used_next;
    logic [slc_pkg::STAMP_W-1:0] clock_reg;
    logic [slc_pkg::STAMP_W-1:0] now_reg;
    logic [slc_pkg::HASH_W-1:0]  hash_reg;
    logic [slc_pkg::TAG_W-1:0]   tag_reg;
    logic [slc_pkg::SIZE_W-1:0]  size_reg;
    logic [slc_pkg::EVICT_W-1:0] evict_reg, evict_next;
    logic                        hit_reg, hit_next;
    logic                        ins_reg, ins_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    logic                        m_valid_reg;
    logic [slc_pkg::M_TDATA_W-1:0] m_data_reg;

    slc_pkg::cell_ctrl_t         ctrl [ENTRIES];
    logic [ENTRIES-1:0]          c_valid, c_hit, c_stale;
    logic [slc_pkg::SIZE_W-1:0]  c_bytes [ENTRIES];

    logic                        l_ok    [ENTRIES+1];
    logic [slc_pkg::STAMP_W-1:0] l_age   [ENTRIES+1];
    logic [IDX_W-1:0]            l_idx   [ENTRIES+1];
    logic [slc_pkg::SIZE_W-1:0]  l_bytes [ENTRIES+1];

    logic                        accept;
    logic                        any_hit, any_stale, any_free, any_valid;
    logic [ENTRIES-1:0]          stale_first, free_first;
    logic [slc_pkg::SIZE_W-1:0]  stale_bytes;
    logic                        over_budget, rejected;
    logic                        out_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == slc_pkg::ST_IDLE);
    assign out_load = (state_reg == slc_pkg::ST_FINISH) && (!m_valid_reg || m_tready);

    // search chain seed: nothing found yet
    assign l_ok[0]    = 1'b0;
    assign l_age[0]   = '0;
    assign l_idx[0]   = '0;
    assign l_bytes[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        slc_cell #(.IDX_W(IDX_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[g]),
            .req_hash  (hash_reg),
            .req_tag   (tag_reg),
            .req_size  (size_reg),
            .now       (now_reg),
            .my_idx    (IDX_W'(g)),
            .lnk_ok    (l_ok[g]),
            .lnk_age   (l_age[g]),
            .lnk_idx   (l_idx[g]),
            .lnk_bytes (l_bytes[g]),
            .out_ok    (l_ok[g+1]),
            .out_age   (l_age[g+1]),
            .out_idx   (l_idx[g+1]),
            .out_bytes (l_bytes[g+1]),
            .valid     (c_valid[g]),
            .hit       (c_hit[g]),
            .stale     (c_stale[g]),
            .bytes     (c_bytes[g])
        );
    end

    // lowest stale entry and lowest free slot, one-hot
    always_comb
    begin
        logic s_seen, f_seen;
        s_seen      = 1'b0;
        f_seen      = 1'b0;
        stale_first = '0;
        free_first  = '0;
        stale_bytes = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (c_stale[i] && !s_seen)
            begin
                stale_first[i] = 1'b1;
                stale_bytes    = c_bytes[i];
                s_seen         = 1'b1;
            end
            if (!c_valid[i] && !f_seen)
            begin
                free_first[i] = 1'b1;
                f_seen        = 1'b1;
            end
        end
    end

    assign any_hit     = |c_hit;
    assign any_stale   = |c_stale;
    assign any_free    = |free_first;
    assign any_valid   = |c_valid;
    assign over_budget = ({1'b0, used_reg} + {1'b0, size_reg}) > {1'b0, budget_reg};
    assign rejected    = (size_reg < min_reg) || (size_reg > budget_reg);

    // controller
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        evict_next = evict_reg;
        hit_next   = hit_reg;
        ins_next   = ins_reg;
        cnt_next   = cnt_reg;
        for (int i = 0; i < ENTRIES; i++)
            ctrl[i] = '0;

        unique case (state_reg)
            slc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    evict_next = '0;
                    hit_next   = 1'b0;
                    ins_next   = 1'b0;
                    state_next = slc_pkg::ST_LOOKUP;
                end
            end
            slc_pkg::ST_LOOKUP:
            begin
                if (any_hit)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        ctrl[i].touch = c_hit[i];
                    hit_next   = 1'b1;
                    state_next = slc_pkg::ST_FINISH;
                end
                else if (rejected)
                    state_next = slc_pkg::ST_FINISH;
                else
                    state_next = slc_pkg::ST_DROP;
            end
            slc_pkg::ST_DROP:
            begin
                // same hash or same stamp: one per cycle
                if (any_stale)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        ctrl[i].drop = stale_first[i];
                    used_next = used_reg - stale_bytes;
                    if (evict_reg != slc_pkg::EVICT_MAX)
                        evict_next = evict_reg + 1'b1;
                end
                else
                    state_next = slc_pkg::ST_CHECK;
            end
            slc_pkg::ST_CHECK:
            begin
                if ((over_budget && any_valid) || !any_free)
                begin
                    cnt_next   = '0;
                    state_next = slc_pkg::ST_SEARCH;
                end
                else
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        ctrl[i].wr = free_first[i];
                    used_next  = used_reg + size_reg;
                    ins_next   = 1'b1;
                    state_next = slc_pkg::ST_FINISH;
                end
            end
            slc_pkg::ST_SEARCH:
            begin
                // token has crossed the whole chain once the count reaches ENTRIES
                if (cnt_reg == CNT_W'(ENTRIES))
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        ctrl[i].drop = (l_idx[ENTRIES] == IDX_W'(i));
                    used_next = used_reg - l_bytes[ENTRIES];
                    if (evict_reg != slc_pkg::EVICT_MAX)
                        evict_next = evict_reg + 1'b1;
                    state_next = slc_pkg::ST_CHECK;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            slc_pkg::ST_FINISH:
            begin
                if (out_load)
                    state_next = slc_pkg::ST_IDLE;
            end
            default:
                state_next = slc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= slc_pkg::ST_IDLE;
            used_reg    <= '0;
            clock_reg   <= '0;
            min_reg     <= '0;
            budget_reg  <= slc_pkg::BUDGET_RST;
            m_valid_reg <= 1'b0;
            evict_reg   <= '0;
            hit_reg     <= 1'b0;
            ins_reg     <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            evict_reg <= evict_next;
            hit_reg   <= hit_next;
            ins_reg   <= ins_next;
            cnt_reg   <= cnt_next;
            if (accept)
                clock_reg <= clock_reg + 1'b1;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    slc_pkg::REG_MIN_SIZE: min_reg    <= cfg_data;
                    slc_pkg::REG_BUDGET:   budget_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hash_reg <= s_tdata[63:0];
            tag_reg  <= s_tdata[127:64];
            size_reg <= s_tdata[159:128];
            now_reg  <= clock_reg;
        end
        if (out_load)
            m_data_reg <= {1'b0, used_reg, evict_reg, ins_reg, hit_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire
